// File: rtl/assert_macros.svh
// Assertion macros used by the I2C bit sequencer top level.
// No dependencies; the asserting module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising clock edge, disabled while reset is low
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/i2cms_pkg.sv
// Types and constants of the I2C master bit sequencer.
// No dependencies; imported by every RTL module of the block.
package i2cms_pkg;

  localparam int unsigned QuarterW = 16;
  localparam int unsigned HoldW    = 17;
  localparam int unsigned ByteW    = 8;
  localparam logic [2:0]  BitTop   = 3'd7;

  // Bus commands, encoded as on the input stream
  typedef enum logic [3:0] {
    OP_RELEASE  = 4'd0,
    OP_START    = 4'd1,
    OP_RESTART  = 4'd2,
    OP_STOP     = 4'd3,
    OP_STOP_TX  = 4'd4,
    OP_WRITE    = 4'd5,
    OP_READ     = 4'd6,
    OP_ACK      = 4'd7,
    OP_NACK     = 4'd8
  } op_e;

  // One classified command as held in the queue
  typedef struct packed {
    op_e               op;
    logic [ByteW-1:0]  tx_byte;
    logic [ByteW-1:0]  rx_line_bits;
    logic              ack_level;
  } cmd_t;

  // One pin phase as delivered on the output stream
  typedef struct packed {
    logic              run_last;
    logic              ack_seen;
    logic [ByteW-1:0]  read_data;
    logic [HoldW-1:0]  hold_ticks;
    logic              sda_level;
    logic              scl_level;
  } phase_t;

endpackage

// File: rtl/i2cms_front.sv
// Front end of the I2C bit sequencer: accepts stream requests, classifies
// the operation and drops unknown codes. Depends on i2cms_pkg.
module i2cms_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [23:0]         in_data_i,
  output logic                push_o,
  output i2cms_pkg::cmd_t     push_cmd_o,
  input  logic                full_i
);
  import i2cms_pkg::*;

  logic   valid_q, valid_d;
  cmd_t   cmd_q, cmd_d;
  logic   accept;
  logic   known;

  // Only codes up to NACK are bus commands
  assign known      = (in_data_i[3:0] <= OP_NACK);
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_cmd_o = cmd_q;

  // Hold the classified request until the queue takes it
  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d            = known;
      cmd_d.op           = op_e'(in_data_i[3:0]);
      cmd_d.tx_byte      = in_data_i[11:4];
      cmd_d.rx_line_bits = in_data_i[19:12];
      cmd_d.ack_level    = in_data_i[20];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: rtl/i2cms_cmd_queue.sv
// Short command queue between the front end and the phase sequencer.
// Depends on i2cms_pkg for the command type.
module i2cms_cmd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cms_pkg::cmd_t  push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output i2cms_pkg::cmd_t  head_o
);
  import i2cms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: rtl/i2cms_back.sv
// Phase sequencer of the I2C bit sequencer: walks one command through its
// run of SCL/SDA phases into an output register. Depends on i2cms_pkg.
module i2cms_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [i2cms_pkg::QuarterW-1:0]      quarter_i,
  input  logic                                cmd_valid_i,
  input  i2cms_pkg::cmd_t                     cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output i2cms_pkg::phase_t                   out_phase_o
);
  import i2cms_pkg::*;

  logic             busy_q, busy_d;
  op_e              op_q, op_d;
  logic [1:0]       sub_q, sub_d;
  logic [2:0]       bit_q, bit_d;
  logic             tail_q, tail_d;
  logic [ByteW-1:0] tx_q, tx_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             ack_q, ack_d;
  logic             scl_held_q, scl_held_d;
  logic             sda_held_q, sda_held_d;
  logic             out_valid_q, out_valid_d;
  phase_t           out_q;
  phase_t           ph;
  logic             advance, gen, load, lv;
  logic [HoldW-1:0] qt, ht;

  assign qt      = {1'b0, quarter_i};
  assign ht      = {quarter_i, 1'b0};
  assign advance = !out_valid_q || out_ready_i;
  assign gen     = busy_q && advance;
  assign load    = cmd_valid_i && (!busy_q || (gen && ph.run_last));
  assign lv      = (op_q == OP_RESTART) || (op_q == OP_NACK);

  assign cmd_pop_o   = load;
  assign out_valid_o = out_valid_q;
  assign out_phase_o = out_q;

  // Build the current phase from command, step counters and held levels
  always_comb begin
    ph = '0;
    case (op_q)
      OP_RELEASE: begin
        ph.scl_level = 1'b1;
        ph.sda_level = 1'b1;
        ph.run_last  = 1'b1;
      end
      OP_START: begin
        ph.scl_level  = 1'b1;
        ph.sda_level  = (sub_q == 2'd0);
        ph.hold_ticks = ht;
        ph.run_last   = (sub_q != 2'd0);
      end
      OP_RESTART, OP_STOP: begin
        ph.hold_ticks = qt;
        case (sub_q)
          2'd0: begin
            ph.sda_level = sda_held_q;
          end
          2'd1: begin
            ph.sda_level = lv;
          end
          2'd2: begin
            ph.scl_level = 1'b1;
            ph.sda_level = lv;
          end
          default: begin
            ph.scl_level = 1'b1;
            ph.sda_level = !lv;
            ph.run_last  = 1'b1;
          end
        endcase
      end
      OP_STOP_TX: begin
        ph.scl_level  = scl_held_q;
        ph.sda_level  = (sub_q != 2'd0);
        ph.hold_ticks = ht;
        ph.run_last   = (sub_q != 2'd0);
      end
      OP_WRITE: begin
        if (tail_q) begin
          ph.scl_level  = (sub_q != 2'd0);
          ph.sda_level  = 1'b1;
          ph.hold_ticks = ht;
          ph.ack_seen   = (sub_q != 2'd0) && ack_q;
          ph.run_last   = (sub_q != 2'd0);
        end else begin
          case (sub_q)
            2'd0: begin
              ph.sda_level  = sda_held_q;
              ph.hold_ticks = qt;
            end
            2'd1: begin
              ph.sda_level  = tx_q[ByteW-1];
              ph.hold_ticks = qt;
            end
            default: begin
              ph.scl_level  = 1'b1;
              ph.sda_level  = tx_q[ByteW-1];
              ph.hold_ticks = ht;
            end
          endcase
        end
      end
      OP_READ: begin
        ph.sda_level = 1'b1;
        case (sub_q)
          2'd0: begin
            ph.hold_ticks = ht;
          end
          2'd1: begin
            ph.scl_level  = 1'b1;
            ph.hold_ticks = qt;
          end
          default: begin
            ph.scl_level  = 1'b1;
            ph.hold_ticks = qt;
            ph.run_last   = (bit_q == BitTop);
            ph.read_data  = (bit_q == BitTop) ? rx_q : '0;
          end
        endcase
      end
      OP_ACK, OP_NACK: begin
        case (sub_q)
          2'd0: begin
            ph.sda_level  = sda_held_q;
            ph.hold_ticks = qt;
          end
          2'd1: begin
            ph.sda_level  = lv;
            ph.hold_ticks = qt;
          end
          default: begin
            ph.scl_level  = 1'b1;
            ph.sda_level  = lv;
            ph.hold_ticks = ht;
            ph.run_last   = 1'b1;
          end
        endcase
      end
      default: begin
        ph = '0;
      end
    endcase
  end

  // Step counters, command load and held pin levels
  always_comb begin
    busy_d      = busy_q;
    op_d        = op_q;
    sub_d       = sub_q;
    bit_d       = bit_q;
    tail_d      = tail_q;
    tx_d        = tx_q;
    rx_d        = rx_q;
    ack_d       = ack_q;
    scl_held_d  = scl_held_q;
    sda_held_d  = sda_held_q;
    out_valid_d = out_valid_q;

    if (advance) begin
      out_valid_d = gen;
    end

    if (gen) begin
      scl_held_d = ph.scl_level;
      sda_held_d = ph.sda_level;
      if (ph.run_last) begin
        busy_d = 1'b0;
      end else if ((op_q == OP_WRITE) && !tail_q && (sub_q == 2'd2)) begin
        sub_d = '0;
        tx_d  = {tx_q[ByteW-2:0], 1'b0};
        if (bit_q == BitTop) begin
          tail_d = 1'b1;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end else if ((op_q == OP_READ) && (sub_q == 2'd2)) begin
        sub_d = '0;
        bit_d = bit_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end

    if (load) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      sub_d  = '0;
      bit_d  = '0;
      tail_d = 1'b0;
      tx_d   = cmd_i.tx_byte;
      rx_d   = cmd_i.rx_line_bits;
      ack_d  = cmd_i.ack_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      op_q        <= OP_RELEASE;
      sub_q       <= '0;
      bit_q       <= '0;
      tail_q      <= 1'b0;
      scl_held_q  <= 1'b1;
      sda_held_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      op_q        <= op_d;
      sub_q       <= sub_d;
      bit_q       <= bit_d;
      tail_q      <= tail_d;
      scl_held_q  <= scl_held_d;
      sda_held_q  <= sda_held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tx_q  <= tx_d;
    rx_q  <= rx_d;
    ack_q <= ack_d;
    if (gen) begin
      out_q <= ph;
    end
  end

endmodule

// File: rtl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer, top level: front end, command queue, phase
// sequencer and the quarter-bit register. Depends on i2cms_pkg and the
// modules i2cms_front, i2cms_cmd_queue, i2cms_back, and assert_macros.svh.
//
// Usage: each request on the s_axis channel is one bus command (release,
// start, restart, stop, stop transmission, write byte, read byte, ACK,
// NACK). The block answers with the run of SCL/SDA pin phases for it on
// the m_axis channel, one phase per transfer, tlast on the final phase.
// Codes above NACK are taken and dropped without any phase.
// An accepted request goes through the front register, the command queue
// and the sequencer state, then its first phase is registered for output.
// The sequencer emits one phase per cycle while the receiver takes them; a
// command has 1 to 26 phases; the next queued one follows with no gap.
// The front end and the sequencer are decoupled by a QueueDepth-entry
// command queue; requests keep being taken while the receiver stalls
// until the queue and the front register fill up.
// cfg_we_i writes the quarter-bit tick count; write it only while idle.
// Reset sets the count to 250, drives no phase and sets both held pin
// levels to released.
module i2c_master_bit_sequencer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] operation, [11:4] tx_byte, [19:12] rx_line_bits, [20] ack_level
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [18:2] hold_ticks, [26:19] read_data,
  // [27] ack_seen, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import i2cms_pkg::*;

  `include "assert_macros.svh"

  logic [QuarterW-1:0] quarter_q;
  logic                push, full, pop, head_valid;
  cmd_t                push_cmd, head_cmd;
  phase_t              phase;

  // Quarter-bit tick count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q <= QuarterW'(250);
    end else if (cfg_we_i) begin
      quarter_q <= cfg_wdata_i;
    end
  end

  i2cms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  i2cms_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quarter_i   (quarter_q),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_phase_o (phase)
  );

  // Pack the phase fields onto the output stream
  assign m_axis_tdata = {4'b0000, phase.ack_seen, phase.read_data, phase.hold_ticks,
                         phase.sda_level, phase.scl_level};
  assign m_axis_tlast = phase.run_last;

  // Read byte and acknowledge appear only on the final phase of a run
  `ASSERT_RST(a_rdata_on_last,
              m_axis_tvalid && (m_axis_tdata[26:19] != 8'h00) |-> m_axis_tlast,
              "read data outside the final phase")
  `ASSERT_RST(a_ack_on_last,
              m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tlast,
              "acknowledge outside the final phase")
  // No phase is offered while reset is held
  `ASSERT_ALWAYS(a_quiet_in_reset,
                 !rst_ni |-> !m_axis_tvalid,
                 "phase offered during reset")

endmodule
